>>> hdl/ibsc_pkg.sv
// Shared widths, defaults and types of the block storage count pipeline.
`timescale 1ns / 1ps

package ibsc_pkg;

  // field widths
  localparam int unsigned SIZE_W = 64;
  localparam int unsigned BS_W   = 16;
  localparam int unsigned CNT_W  = 40;

  // block size after reset
  localparam logic [BS_W-1:0] BS_RESET = 16'd4096;

  // parameter defaults
  localparam int unsigned DIRECT_POINTERS_DEF = 12;
  localparam int unsigned POINTER_BYTES_DEF   = 8;

  // pointers per block is at most block size / 2
  localparam int unsigned P_W   = BS_W - 1;
  localparam int unsigned P2_W  = 2 * P_W;
  localparam int unsigned P3_W  = 3 * P_W;
  localparam int unsigned CAP_W = P3_W + 2;

  // running total width in the final adders
  localparam int unsigned SUM_W = CNT_W + 2;

  // tier geometry derived from the block size register
  typedef struct packed {
    logic [P_W-1:0]   p;
    logic [P2_W-1:0]  p2;
    logic [CAP_W-1:0] cap;
  } geom_t;

endpackage

>>> hdl/ibsc_div_pipe.sv
// Pipelined restoring divider, one quotient bit per register stage.
`timescale 1ns / 1ps

module ibsc_div_pipe #(
  parameter int unsigned NW = 64,
  parameter int unsigned DW = 16,
  parameter int unsigned SW = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic [NW-1:0] in_dividend,
  input  logic [DW-1:0] divisor,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  output logic [NW-1:0] out_quot,
  output logic          out_rem_nz,
  output logic [SW-1:0] out_side
);

  // per stage: valid, partial remainder, dividend bits shifting out / quotient shifting in
  logic          v_r    [NW];
  logic [DW-1:0] rem_r  [NW];
  logic [NW-1:0] num_r  [NW];
  logic [SW-1:0] side_r [NW];

  for (genvar i = 0; i < NW; i++) begin : g_stage
    logic          v_i;
    logic [DW-1:0] rem_i;
    logic [NW-1:0] num_i;
    logic [SW-1:0] side_i;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          ge;
    logic [DW-1:0] rem_nxt;
    logic [NW-1:0] num_nxt;

    if (i == 0) begin : g_first
      assign v_i    = in_valid;
      assign rem_i  = '0;
      assign num_i  = in_dividend;
      assign side_i = in_side;
    end else begin : g_next
      assign v_i    = v_r[i-1];
      assign rem_i  = rem_r[i-1];
      assign num_i  = num_r[i-1];
      assign side_i = side_r[i-1];
    end

    // bring down the next dividend bit, subtract when it fits
    assign trial   = {rem_i, num_i[NW-1]};
    assign ge      = (trial >= {1'b0, divisor});
    assign diff    = trial - {1'b0, divisor};
    assign rem_nxt = ge ? diff[DW-1:0] : trial[DW-1:0];
    assign num_nxt = {num_i[NW-2:0], ge};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else begin
        v_r[i] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      rem_r[i]  <= rem_nxt;
      num_r[i]  <= num_nxt;
      side_r[i] <= side_i;
    end
  end

  assign out_valid  = v_r[NW-1];
  assign out_quot   = num_r[NW-1];
  assign out_rem_nz = |rem_r[NW-1];
  assign out_side   = side_r[NW-1];

endmodule

>>> hdl/ibsc_tier.sv
// Tier split, pointer block dividers and final count assembly.
`timescale 1ns / 1ps

module ibsc_tier #(
  parameter int unsigned DIRECT_POINTERS = ibsc_pkg::DIRECT_POINTERS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic [ibsc_pkg::SIZE_W-1:0] in_quot,
  input  logic                       in_rem_nz,
  input  logic                       in_bs_zero,
  input  ibsc_pkg::geom_t            geom,
  output logic                       out_valid,
  output logic [ibsc_pkg::CNT_W-1:0] out_data_blocks,
  output logic [ibsc_pkg::CNT_W-1:0] out_total_blocks,
  output logic                       out_too_big
);

  import ibsc_pkg::*;

  typedef struct packed {
    logic big;
    logic sgl;
    logic dbl;
  } flags_t;

  localparam logic [CNT_W-1:0] DIRECT = CNT_W'(DIRECT_POINTERS);

  // stage 1: round up the data count, flag counts past 40 bits and a zero block size
  logic [SIZE_W-1:0] data64;
  logic              s1_v_r, s1_big_r;
  logic [CNT_W-1:0]  s1_data_r;
  logic              s1_big_nxt;

  assign data64     = in_quot + SIZE_W'(in_rem_nz);
  assign s1_big_nxt = in_bs_zero | (|data64[SIZE_W-1:CNT_W]);

  // stage 2: blocks beyond the direct pointers
  logic              direct_only;
  logic [CNT_W-1:0]  s2_rem_nxt;
  logic              s2_v_r, s2_big_r, s2_sgl_r;
  logic [CNT_W-1:0]  s2_data_r, s2_rem_r;

  assign direct_only = (s1_data_r <= DIRECT);
  assign s2_rem_nxt  = direct_only ? '0 : s1_data_r - DIRECT;

  // stage 3: capacity check, split off the singly tier
  logic              over, gt_p;
  logic [CNT_W-1:0]  s3_r2_nxt;
  logic              s3_v_r, s3_big_r, s3_sgl_r, s3_dbl_r;
  logic [CNT_W-1:0]  s3_data_r, s3_r2_r;

  assign over      = ({(CAP_W-CNT_W)'(0), s2_rem_r} > geom.cap);
  assign gt_p      = (s2_rem_r > CNT_W'(geom.p));
  assign s3_r2_nxt = gt_p ? s2_rem_r - CNT_W'(geom.p) : '0;

  // stage 4: split the doubly tier from the triply tier
  logic              gt_p2;
  logic [CNT_W-1:0]  s4_n_nxt, s4_r3_nxt;
  logic              s4_v_r, s4_big_r, s4_sgl_r, s4_dbl_r, s4_tpl_r;
  logic [CNT_W-1:0]  s4_data_r, s4_n_r, s4_r3_r;
  flags_t            s4_flags;

  assign gt_p2     = (s3_r2_r > CNT_W'(geom.p2));
  assign s4_n_nxt  = gt_p2 ? CNT_W'(geom.p2) : s3_r2_r;
  assign s4_r3_nxt = gt_p2 ? s3_r2_r - CNT_W'(geom.p2) : '0;
  assign s4_flags  = '{big: s4_big_r, sgl: s4_sgl_r, dbl: s4_dbl_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
    end else begin
      s1_v_r <= in_valid;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      s4_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_big_r  <= s1_big_nxt;
    s1_data_r <= data64[CNT_W-1:0];
    s2_big_r  <= s1_big_r;
    s2_sgl_r  <= ~direct_only;
    s2_data_r <= s1_data_r;
    s2_rem_r  <= s2_rem_nxt;
    s3_big_r  <= s2_big_r | over;
    s3_sgl_r  <= s2_sgl_r;
    s3_dbl_r  <= gt_p;
    s3_data_r <= s2_data_r;
    s3_r2_r   <= s3_r2_nxt;
    s4_big_r  <= s3_big_r;
    s4_sgl_r  <= s3_sgl_r;
    s4_dbl_r  <= s3_dbl_r;
    s4_tpl_r  <= gt_p2;
    s4_data_r <= s3_data_r;
    s4_n_r    <= s4_n_nxt;
    s4_r3_r   <= s4_r3_nxt;
  end

  // three lanes of equal depth: singly blocks of the doubly tier,
  // doubly blocks and singly blocks of the triply tier
  logic              va, vb, vc;
  logic [CNT_W-1:0]  qa, qb, qc;
  logic              nza, nzb, nzc;
  logic [CNT_W-1:0]  da_data;
  flags_t            db_flags;
  logic              dc_tpl;

  ibsc_div_pipe #(.NW(CNT_W), .DW(P_W), .SW(CNT_W)) u_div_dbl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (s4_v_r),
    .in_dividend(s4_n_r),
    .divisor    (geom.p),
    .in_side    (s4_data_r),
    .out_valid  (va),
    .out_quot   (qa),
    .out_rem_nz (nza),
    .out_side   (da_data)
  );

  ibsc_div_pipe #(.NW(CNT_W), .DW(P2_W), .SW($bits(flags_t))) u_div_tpl2 (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (s4_v_r),
    .in_dividend(s4_r3_r),
    .divisor    (geom.p2),
    .in_side    (s4_flags),
    .out_valid  (vb),
    .out_quot   (qb),
    .out_rem_nz (nzb),
    .out_side   (db_flags)
  );

  ibsc_div_pipe #(.NW(CNT_W), .DW(P_W), .SW(1)) u_div_tpl1 (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (s4_v_r),
    .in_dividend(s4_r3_r),
    .divisor    (geom.p),
    .in_side    (s4_tpl_r),
    .out_valid  (vc),
    .out_quot   (qc),
    .out_rem_nz (nzc),
    .out_side   (dc_tpl)
  );

  // stage 5: round up each pointer block count
  logic              s5_v_r, s5_big_r, s5_sgl_r, s5_dbl_r, s5_tpl_r;
  logic [CNT_W-1:0]  s5_data_r, s5_ca_r, s5_cb_r, s5_cc_r;

  // stage 6: partial sums per tier
  logic [SUM_W-1:0]  s6_a_nxt, s6_b_nxt;
  logic              s6_v_r, s6_big_r;
  logic [CNT_W-1:0]  s6_data_r;
  logic [SUM_W-1:0]  s6_a_r, s6_b_r;

  assign s6_a_nxt = SUM_W'(s5_data_r) + SUM_W'(s5_sgl_r)
                  + (s5_dbl_r ? SUM_W'(s5_ca_r) + SUM_W'(1) : '0);
  assign s6_b_nxt = s5_tpl_r ? SUM_W'(s5_cb_r) + SUM_W'(s5_cc_r) + SUM_W'(1) : '0;

  // stage 7: final total, output registers
  logic [SUM_W-1:0]  total;
  logic              big;
  logic              out_valid_r, out_too_big_r;
  logic [CNT_W-1:0]  out_data_r, out_total_r;

  assign total = s6_a_r + s6_b_r;
  assign big   = s6_big_r | (|total[SUM_W-1:CNT_W]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_v_r      <= 1'b0;
      s6_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s5_v_r      <= va;
      s6_v_r      <= s5_v_r;
      out_valid_r <= s6_v_r;
    end
  end

  always_ff @(posedge clk) begin
    s5_big_r      <= db_flags.big;
    s5_sgl_r      <= db_flags.sgl;
    s5_dbl_r      <= db_flags.dbl;
    s5_tpl_r      <= dc_tpl;
    s5_data_r     <= da_data;
    s5_ca_r       <= qa + CNT_W'(nza);
    s5_cb_r       <= qb + CNT_W'(nzb);
    s5_cc_r       <= qc + CNT_W'(nzc);
    s6_big_r      <= s5_big_r;
    s6_data_r     <= s5_data_r;
    s6_a_r        <= s6_a_nxt;
    s6_b_r        <= s6_b_nxt;
    out_too_big_r <= big;
    out_data_r    <= big ? '0 : s6_data_r;
    out_total_r   <= big ? '0 : total[CNT_W-1:0];
  end

  assign out_valid        = out_valid_r;
  assign out_data_blocks  = out_data_r;
  assign out_total_blocks = out_total_r;
  assign out_too_big      = out_too_big_r;

`ifndef NO_ASSERTIONS
  // the three divider lanes stay in lockstep
  a_lanes_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    (va == vb) && (vb == vc))
    else $error("tier divider lanes out of step");

  // a triply tier needs a doubly tier, a doubly tier needs a singly tier
  a_tier_order: assert property (@(posedge clk) disable iff (!rst_n)
    s4_v_r && s4_tpl_r |-> s4_dbl_r && s4_sgl_r)
    else $error("tier flags out of order");
`endif

endmodule

>>> hdl/indirect_block_storage_count_top.sv
// Top level: block size register, tier geometry and the counting pipeline.
`timescale 1ns / 1ps

// Channel   Transfer when              Payload
// input     start && !busy             in_byte_size
// result    out_valid (one cycle)      out_data_blocks, out_total_blocks, out_too_big
// config    cfg_valid && cfg_ready     cfg_block_size
//
// One item per cycle while busy is low; each result passes 111 register stages (64
// stages of the size divider, four tier stages, 40 stages of the pointer block dividers,
// three summing stages). busy is set while rst_n is low and cleared once it is high;
// cfg_ready is its inverse. Tier geometry settles through p_r, p2_r, p3_r and cap_r
// after a block size write. The pipeline never stalls, since results cannot be held off.

module indirect_block_storage_count_top #(
  parameter int unsigned DIRECT_POINTERS = ibsc_pkg::DIRECT_POINTERS_DEF,
  parameter int unsigned POINTER_BYTES   = ibsc_pkg::POINTER_BYTES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [ibsc_pkg::SIZE_W-1:0] in_byte_size,
  output logic                        out_valid,
  output logic [ibsc_pkg::CNT_W-1:0]  out_data_blocks,
  output logic [ibsc_pkg::CNT_W-1:0]  out_total_blocks,
  output logic                        out_too_big,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [ibsc_pkg::BS_W-1:0]   cfg_block_size
);

  import ibsc_pkg::*;

  // block size / pointer bytes as multiply by reciprocal, exact for 16-bit sizes
  localparam int unsigned RECIP_SH = BS_W + 4;
  localparam int unsigned RECIP_W  = RECIP_SH;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << RECIP_SH) + POINTER_BYTES - 1) / POINTER_BYTES);

  // control and configuration registers
  logic            busy_r;
  logic [BS_W-1:0] block_size_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r       <= 1'b1;
      block_size_r <= BS_RESET;
    end else begin
      busy_r <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        block_size_r <= cfg_block_size;
      end
    end
  end

  assign busy      = busy_r;
  assign cfg_ready = ~busy_r;

  // tier geometry chain: pointers per block, its square, cube and total capacity
  logic [BS_W+RECIP_W-1:0] p_prod;
  logic [P_W-1:0]          p_r;
  logic [P2_W-1:0]         p2_r;
  logic [P3_W-1:0]         p3_r;
  logic [CAP_W-1:0]        cap_r;
  logic [CAP_W-1:0]        cap_nxt;
  geom_t                   geom;

  assign p_prod  = (BS_W+RECIP_W)'(block_size_r) * (BS_W+RECIP_W)'(RECIP);
  assign cap_nxt = CAP_W'(p_r) + CAP_W'(p2_r) + CAP_W'(p3_r);

  always_ff @(posedge clk) begin
    p_r   <= p_prod[RECIP_SH +: P_W];
    p2_r  <= P2_W'(p_r) * P2_W'(p_r);
    p3_r  <= P3_W'(p2_r) * P3_W'(p_r);
    cap_r <= cap_nxt;
  end

  assign geom = '{p: p_r, p2: p2_r, cap: cap_r};

  // size divider: data blocks before rounding
  logic              in_xfer;
  logic              dv_valid;
  logic [SIZE_W-1:0] dv_quot;
  logic              dv_rem_nz;
  logic              dv_bs_zero;

  assign in_xfer = start & ~busy_r;

  ibsc_div_pipe #(.NW(SIZE_W), .DW(BS_W), .SW(1)) u_div_size (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_xfer),
    .in_dividend(in_byte_size),
    .divisor    (block_size_r),
    .in_side    (block_size_r == '0),
    .out_valid  (dv_valid),
    .out_quot   (dv_quot),
    .out_rem_nz (dv_rem_nz),
    .out_side   (dv_bs_zero)
  );

  // tier split and totals
  ibsc_tier #(.DIRECT_POINTERS(DIRECT_POINTERS)) u_tier (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (dv_valid),
    .in_quot         (dv_quot),
    .in_rem_nz       (dv_rem_nz),
    .in_bs_zero      (dv_bs_zero),
    .geom            (geom),
    .out_valid       (out_valid),
    .out_data_blocks (out_data_blocks),
    .out_total_blocks(out_total_blocks),
    .out_too_big     (out_too_big)
  );

`ifndef NO_ASSERTIONS
  // an oversized result carries no counts
  a_big_clears: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_too_big |-> (out_data_blocks == '0) && (out_total_blocks == '0))
    else $error("too_big result with nonzero counts");

  // pointer blocks only add to the data count
  a_total_ge_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_too_big |-> out_total_blocks >= out_data_blocks)
    else $error("total below data count");

  // reset empties the pipeline
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result strobe right after reset");
`endif

endmodule
